@@ design/byte_credit_command_streamer_defines.svh @@
// Assertion macros used by the streamer back end.
`ifndef BYTE_CREDIT_COMMAND_STREAMER_DEFINES_SVH
`define BYTE_CREDIT_COMMAND_STREAMER_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define BCCS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define BCCS_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ design/bccs_pkg.sv @@
// Shared types and constants of the byte credit command streamer.
package bccs_pkg;

  localparam int unsigned SENT_DEPTH_DEF = 16;
  localparam int unsigned WAIT_DEPTH_DEF = 16;
  localparam int unsigned CMDQ_DEPTH     = 2;
  localparam logic [7:0]  BUF_RESET      = 8'd128;
  localparam int unsigned ENTRY_W        = 24;

  typedef enum logic [1:0] {
    KIND_SUBMIT = 2'd0,
    KIND_OK     = 2'd1,
    KIND_ERROR  = 2'd2,
    KIND_RESET  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    EV_SENT        = 4'd0,
    EV_QUEUED      = 4'd1,
    EV_REJECTED    = 4'd2,
    EV_OK          = 4'd3,
    EV_ERROR       = 4'd4,
    EV_LOST_SENT   = 4'd5,
    EV_LOST_UNSENT = 4'd6,
    EV_STRAY_OK    = 4'd7,
    EV_STRAY_ERROR = 4'd8,
    EV_RESET_DONE  = 4'd9
  } event_e;

  // Classified request handed from the front to the back.
  typedef struct packed {
    kind_e       kind;
    logic [15:0] id;
    logic [7:0]  bytes;
    logic        reject;
    logic [7:0]  code;
  } cmd_t;

  // Entry of the sent and waiting queues.
  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  bytes;
  } entry_t;

  typedef struct packed {
    event_e      res;
    logic [15:0] id;
    logic [7:0]  code;
    logic [7:0]  bytes;
  } event_t;

endpackage

@@ design/byte_credit_command_streamer.sv @@
// Byte credit command streamer: top level with config register, front and back end.
// A submit yields a single result event.
// Ok/error: its result, then a sent event for each waiting command drained.
// Reset request: a lost event per sent and waiting entry, then reset done.
// The back end takes one request at a time; a stalled result output holds it.
// rst_ni clears counts, pointers and credit; buffer size returns to 128 bytes.
module byte_credit_command_streamer #(
  parameter int unsigned SENT_DEPTH = bccs_pkg::SENT_DEPTH_DEF,
  parameter int unsigned WAIT_DEPTH = bccs_pkg::WAIT_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [15:0] correlation_id_i,
  input  logic [7:0]  command_length_i,
  input  logic        ends_with_newline_i,
  input  logic        early_newline_i,
  input  logic        has_carriage_return_i,
  input  logic [7:0]  reply_error_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  event_res_o,
  output logic [15:0] event_id_o,
  output logic [7:0]  event_error_code_o,
  output logic [7:0]  event_bytes_o,
  output logic        last_o
);

  logic [7:0]       buf_bytes_q;
  logic             cmd_valid;
  bccs_pkg::cmd_t   cmd;
  logic             cmd_pop;
  bccs_pkg::event_t out_event;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_bytes_q <= bccs_pkg::BUF_RESET;
    end else if (cfg_we_i) begin
      buf_bytes_q <= cfg_wdata_i;
    end
  end

  bccs_front u_front (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .kind_i                (kind_i),
    .correlation_id_i      (correlation_id_i),
    .command_length_i      (command_length_i),
    .ends_with_newline_i   (ends_with_newline_i),
    .early_newline_i       (early_newline_i),
    .has_carriage_return_i (has_carriage_return_i),
    .reply_error_code_i    (reply_error_code_i),
    .buf_bytes_i           (buf_bytes_q),
    .cmd_valid_o           (cmd_valid),
    .cmd_o                 (cmd),
    .cmd_pop_i             (cmd_pop)
  );

  bccs_back #(
    .SENT_DEPTH (SENT_DEPTH),
    .WAIT_DEPTH (WAIT_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .buf_bytes_i (buf_bytes_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_event_o (out_event),
    .out_last_o  (last_o)
  );

  assign event_res_o        = out_event.res;
  assign event_id_o         = out_event.id;
  assign event_error_code_o = out_event.code;
  assign event_bytes_o      = out_event.bytes;

endmodule

@@ design/bccs_ram.sv @@
// Generic single write port RAM with registered read.
module bccs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/bccs_front.sv @@
// Front end: accepts requests, validates submits and queues all requests for the back end.
module bccs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        kind_i,
  input  logic [15:0]       correlation_id_i,
  input  logic [7:0]        command_length_i,
  input  logic              ends_with_newline_i,
  input  logic              early_newline_i,
  input  logic              has_carriage_return_i,
  input  logic [7:0]        reply_error_code_i,
  input  logic [7:0]        buf_bytes_i,
  output logic              cmd_valid_o,
  output bccs_pkg::cmd_t    cmd_o,
  input  logic              cmd_pop_i
);

  localparam int unsigned QD  = bccs_pkg::CMDQ_DEPTH;
  localparam int unsigned QAW = (QD > 1) ? $clog2(QD) : 1;
  localparam int unsigned QCW = $clog2(QD + 1);

  bccs_pkg::cmd_t q_mem [QD];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] cnt_q, cnt_d;

  bccs_pkg::cmd_t cmd_new;
  logic [8:0]     len_ext;
  logic [8:0]     bytes_fix;
  logic           push;
  logic           pop;

  // Append a newline when missing; an empty command always gets one.
  always_comb begin
    len_ext   = {1'b0, command_length_i};
    bytes_fix = ((command_length_i == 8'd0) || !ends_with_newline_i) ? len_ext + 9'd1
                                                                      : len_ext;
    cmd_new.kind   = bccs_pkg::kind_e'(kind_i);
    cmd_new.id     = correlation_id_i;
    cmd_new.bytes  = bytes_fix[7:0];
    cmd_new.reject = (bytes_fix > {1'b0, buf_bytes_i}) || early_newline_i ||
                     has_carriage_return_i;
    cmd_new.code   = (bccs_pkg::kind_e'(kind_i) == bccs_pkg::KIND_ERROR) ?
                     reply_error_code_i : 8'd0;
  end

  assign in_ready_o  = (cnt_q != QCW'(QD));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QAW'(QD - 1)) ? '0 : wr_ptr_q + QAW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QAW'(QD - 1)) ? '0 : rd_ptr_q + QAW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + QCW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

@@ design/bccs_back.sv @@
// Back end: credit accounting, sent and waiting queues, and the result stream.
`include "byte_credit_command_streamer_defines.svh"

module bccs_back #(
  parameter int unsigned SENT_DEPTH = bccs_pkg::SENT_DEPTH_DEF,
  parameter int unsigned WAIT_DEPTH = bccs_pkg::WAIT_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      buf_bytes_i,
  input  logic            cmd_valid_i,
  input  bccs_pkg::cmd_t  cmd_i,
  output logic            cmd_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bccs_pkg::event_t out_event_o,
  output logic            out_last_o
);

  localparam int unsigned SAW = (SENT_DEPTH > 1) ? $clog2(SENT_DEPTH) : 1;
  localparam int unsigned WAW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int unsigned SCW = $clog2(SENT_DEPTH + 1);
  localparam int unsigned WCW = $clog2(WAIT_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETTLE,
    S_DRAIN,
    S_LOSTS,
    S_LOSTW,
    S_DONE,
    S_FLUSH
  } state_e;

  state_e state_q, state_d;
  state_e ret_q, ret_d;

  logic [SAW-1:0] sent_head_q, sent_head_d;
  logic [SCW-1:0] sent_cnt_q, sent_cnt_d;
  logic [WAW-1:0] wait_head_q, wait_head_d;
  logic [WCW-1:0] wait_cnt_q, wait_cnt_d;
  logic [7:0]     outst_q, outst_d;

  logic             pend_valid_q, pend_valid_d;
  bccs_pkg::event_t pend_q, pend_d;
  logic             out_valid_q, out_valid_d;
  bccs_pkg::event_t out_q, out_d;
  logic             out_last_q, out_last_d;

  logic                  sent_we, wait_we;
  bccs_pkg::entry_t      sent_wdata, wait_wdata;
  logic [bccs_pkg::ENTRY_W-1:0] sent_rbits, wait_rbits;
  bccs_pkg::entry_t      sent_rd, wait_rd;
  logic [SAW-1:0]        sent_tail;
  logic [WAW-1:0]        wait_tail;
  logic [SCW:0]          sent_sum;
  logic [WCW:0]          wait_sum;
  logic [SAW-1:0]        sent_head_inc;
  logic [WAW-1:0]        wait_head_inc;
  logic                  out_free;
  logic                  push_ok;
  logic [7:0]            outst_ret;
  logic                  cmd_fits;
  logic                  wait_fits;

  function automatic logic credit_ok(input logic [7:0] outst, input logic [7:0] bytes,
                                     input logic [7:0] buf_bytes);
    logic [8:0] sum;
    sum = {1'b0, outst} + {1'b0, bytes};
    return sum <= {1'b0, buf_bytes};
  endfunction

  bccs_ram #(
    .WIDTH (bccs_pkg::ENTRY_W),
    .DEPTH (SENT_DEPTH)
  ) u_sent_ram (
    .clk_i   (clk_i),
    .we_i    (sent_we),
    .waddr_i (sent_tail),
    .wdata_i (sent_wdata),
    .raddr_i (sent_head_q),
    .rdata_o (sent_rbits)
  );

  bccs_ram #(
    .WIDTH (bccs_pkg::ENTRY_W),
    .DEPTH (WAIT_DEPTH)
  ) u_wait_ram (
    .clk_i   (clk_i),
    .we_i    (wait_we),
    .waddr_i (wait_tail),
    .wdata_i (wait_wdata),
    .raddr_i (wait_head_q),
    .rdata_o (wait_rbits)
  );

  assign sent_rd = bccs_pkg::entry_t'(sent_rbits);
  assign wait_rd = bccs_pkg::entry_t'(wait_rbits);

  always_comb begin
    sent_sum  = (SCW + 1)'(sent_head_q) + (SCW + 1)'(sent_cnt_q);
    sent_tail = (sent_sum >= (SCW + 1)'(SENT_DEPTH)) ?
                SAW'(sent_sum - (SCW + 1)'(SENT_DEPTH)) : SAW'(sent_sum);
    wait_sum  = (WCW + 1)'(wait_head_q) + (WCW + 1)'(wait_cnt_q);
    wait_tail = (wait_sum >= (WCW + 1)'(WAIT_DEPTH)) ?
                WAW'(wait_sum - (WCW + 1)'(WAIT_DEPTH)) : WAW'(wait_sum);
    sent_head_inc = (sent_head_q == SAW'(SENT_DEPTH - 1)) ? '0 : sent_head_q + SAW'(1);
    wait_head_inc = (wait_head_q == WAW'(WAIT_DEPTH - 1)) ? '0 : wait_head_q + WAW'(1);
  end

  assign out_free  = !out_valid_q || out_ready_i;
  assign push_ok   = !pend_valid_q || out_free;
  assign outst_ret = (outst_q >= sent_rd.bytes) ? outst_q - sent_rd.bytes : 8'd0;
  assign cmd_fits  = (sent_cnt_q < SCW'(SENT_DEPTH)) &&
                     credit_ok(outst_q, cmd_i.bytes, buf_bytes_i);
  assign wait_fits = (wait_cnt_q != '0) && (sent_cnt_q < SCW'(SENT_DEPTH)) &&
                     credit_ok(outst_q, wait_rd.bytes, buf_bytes_i);

  always_comb begin
    state_d      = state_q;
    ret_d        = ret_q;
    sent_head_d  = sent_head_q;
    sent_cnt_d   = sent_cnt_q;
    wait_head_d  = wait_head_q;
    wait_cnt_d   = wait_cnt_q;
    outst_d      = outst_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    out_last_d   = out_last_q;
    sent_we      = 1'b0;
    wait_we      = 1'b0;
    sent_wdata   = '{id: cmd_i.id, bytes: cmd_i.bytes};
    wait_wdata   = '{id: cmd_i.id, bytes: cmd_i.bytes};
    cmd_pop_o    = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            bccs_pkg::KIND_SUBMIT: begin
              pend_valid_d = 1'b1;
              pend_d = '{res: bccs_pkg::EV_REJECTED, id: cmd_i.id, code: 8'd0, bytes: 8'd0};
              if (!cmd_i.reject && (wait_cnt_q == '0) && cmd_fits) begin
                sent_we    = 1'b1;
                sent_cnt_d = sent_cnt_q + SCW'(1);
                outst_d    = outst_q + cmd_i.bytes;
                pend_d.res   = bccs_pkg::EV_SENT;
                pend_d.bytes = cmd_i.bytes;
              end else if (!cmd_i.reject && (wait_cnt_q < WCW'(WAIT_DEPTH))) begin
                wait_we    = 1'b1;
                wait_cnt_d = wait_cnt_q + WCW'(1);
                pend_d.res = bccs_pkg::EV_QUEUED;
              end
              state_d = S_FLUSH;
            end
            bccs_pkg::KIND_OK, bccs_pkg::KIND_ERROR: begin
              pend_valid_d = 1'b1;
              if (sent_cnt_q == '0) begin
                pend_d = '{res: (cmd_i.kind == bccs_pkg::KIND_OK) ? bccs_pkg::EV_STRAY_OK
                                                                  : bccs_pkg::EV_STRAY_ERROR,
                           id: 16'd0, code: cmd_i.code, bytes: 8'd0};
              end else begin
                pend_d = '{res: (cmd_i.kind == bccs_pkg::KIND_OK) ? bccs_pkg::EV_OK
                                                                  : bccs_pkg::EV_ERROR,
                           id: sent_rd.id, code: cmd_i.code, bytes: 8'd0};
                sent_head_d = sent_head_inc;
                sent_cnt_d  = sent_cnt_q - SCW'(1);
                outst_d     = outst_ret;
              end
              state_d = S_SETTLE;
              ret_d   = S_DRAIN;
            end
            bccs_pkg::KIND_RESET: begin
              if (sent_cnt_q != '0) begin
                state_d = S_LOSTS;
              end else if (wait_cnt_q != '0) begin
                state_d = S_LOSTW;
              end else begin
                state_d = S_DONE;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // Wait for the queue heads to be read back from the RAMs.
      S_SETTLE: begin
        state_d = ret_q;
      end

      S_DRAIN: begin
        if (!wait_fits) begin
          state_d = S_FLUSH;
        end else if (push_ok) begin
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_d       = pend_q;
            out_last_d  = 1'b0;
          end
          pend_valid_d = 1'b1;
          pend_d = '{res: bccs_pkg::EV_SENT, id: wait_rd.id, code: 8'd0, bytes: wait_rd.bytes};
          sent_we     = 1'b1;
          sent_wdata  = wait_rd;
          sent_cnt_d  = sent_cnt_q + SCW'(1);
          outst_d     = outst_q + wait_rd.bytes;
          wait_head_d = wait_head_inc;
          wait_cnt_d  = wait_cnt_q - WCW'(1);
          state_d     = S_SETTLE;
          ret_d       = S_DRAIN;
        end
      end

      S_LOSTS: begin
        if (push_ok) begin
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_d       = pend_q;
            out_last_d  = 1'b0;
          end
          pend_valid_d = 1'b1;
          pend_d = '{res: bccs_pkg::EV_LOST_SENT, id: sent_rd.id, code: 8'd0, bytes: 8'd0};
          sent_head_d = sent_head_inc;
          sent_cnt_d  = sent_cnt_q - SCW'(1);
          if (sent_cnt_q == SCW'(1)) begin
            state_d = (wait_cnt_q != '0) ? S_LOSTW : S_DONE;
          end else begin
            state_d = S_SETTLE;
            ret_d   = S_LOSTS;
          end
        end
      end

      S_LOSTW: begin
        if (push_ok) begin
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_d       = pend_q;
            out_last_d  = 1'b0;
          end
          pend_valid_d = 1'b1;
          pend_d = '{res: bccs_pkg::EV_LOST_UNSENT, id: wait_rd.id, code: 8'd0, bytes: 8'd0};
          wait_head_d = wait_head_inc;
          wait_cnt_d  = wait_cnt_q - WCW'(1);
          if (wait_cnt_q == WCW'(1)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SETTLE;
            ret_d   = S_LOSTW;
          end
        end
      end

      S_DONE: begin
        if (push_ok) begin
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_d       = pend_q;
            out_last_d  = 1'b0;
          end
          pend_valid_d = 1'b1;
          pend_d = '{res: bccs_pkg::EV_RESET_DONE, id: 16'd0, code: 8'd0, bytes: 8'd0};
          sent_head_d = '0;
          wait_head_d = '0;
          outst_d     = 8'd0;
          state_d     = S_FLUSH;
        end
      end

      // Hand over the final event of the request.
      S_FLUSH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_d        = pend_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ret_q        <= S_IDLE;
      sent_head_q  <= '0;
      sent_cnt_q   <= '0;
      wait_head_q  <= '0;
      wait_cnt_q   <= '0;
      outst_q      <= 8'd0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      ret_q        <= ret_d;
      sent_head_q  <= sent_head_d;
      sent_cnt_q   <= sent_cnt_d;
      wait_head_q  <= wait_head_d;
      wait_cnt_q   <= wait_cnt_d;
      outst_q      <= outst_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_event_o = out_q;
  assign out_last_o  = out_last_q;

  `BCCS_ASSERT_ALWAYS(a_sent_cnt_range, sent_cnt_q <= SCW'(SENT_DEPTH), "sent count overflow")
  `BCCS_ASSERT_ALWAYS(a_wait_cnt_range, wait_cnt_q <= WCW'(WAIT_DEPTH), "wait count overflow")
  `BCCS_ASSERT_IMPLIES(a_credit_idle, (state_q == S_IDLE) && (sent_cnt_q == '0), outst_q == 8'd0, "credit leak with nothing sent")
  `BCCS_ASSERT_IMPLIES(a_pend_idle, state_q == S_IDLE, !pend_valid_q, "pending event left in idle")

endmodule
